/* sv/nuns_pkg.sv */
package nuns_pkg;

  localparam int NODE_BITS = 6;
  localparam int DIST_BITS = 25;
  localparam int COUNT_BITS = 7;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_CLOSEST = 2'd1;
  localparam logic [1:0] ACT_DISTANCE = 2'd2;

  localparam logic [DIST_BITS-1:0] DIST_ONES = '1;

  typedef struct packed {
    logic                 valid;
    logic [NODE_BITS-1:0] idx;
  } tag_t;

endpackage

/* sv/nuns_cell.sv */
module nuns_cell #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         shift,
  input  logic signed [COORD_BITS-1:0] x_in,
  input  logic signed [COORD_BITS-1:0] y_in,
  output logic signed [COORD_BITS-1:0] x_out,
  output logic signed [COORD_BITS-1:0] y_out
);

  logic signed [COORD_BITS-1:0] x;
  logic signed [COORD_BITS-1:0] y;

  always_ff @(posedge clk) begin
    if (shift) begin
      x <= x_in;
      y <= y_in;
    end
  end

  assign x_out = x;
  assign y_out = y;

endmodule

/* sv/nuns_dist.sv */
module nuns_dist #(
  parameter int COORD_BITS = 16,
  parameter int SUM_BITS = 2 * COORD_BITS + 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  nuns_pkg::tag_t               tag_in,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  output nuns_pkg::tag_t               tag_out,
  output logic [SUM_BITS-1:0]          sum
);

  localparam int DW = COORD_BITS + 1;
  localparam int SQW = 2 * DW;

  logic signed [DW-1:0] dx_s;
  logic signed [DW-1:0] dy_s;
  logic [DW-1:0] dx;
  logic [DW-1:0] dy;
  logic [SQW-1:0] sqx;
  logic [SQW-1:0] sqy;
  nuns_pkg::tag_t tag1;
  nuns_pkg::tag_t tag2;
  logic [SUM_BITS-1:0] sum_r;
  nuns_pkg::tag_t tag3;

  always_comb begin
    dx_s = DW'(ax) - DW'(bx);
    dy_s = DW'(ay) - DW'(by);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid <= 1'b0;
      tag2.valid <= 1'b0;
      tag3.valid <= 1'b0;
    end else begin
      tag1 <= tag_in;
      tag2 <= tag1;
      tag3 <= tag2;
    end
    dx <= dx_s[DW-1] ? DW'(-dx_s) : DW'(dx_s);
    dy <= dy_s[DW-1] ? DW'(-dy_s) : DW'(dy_s);
    sqx <= SQW'(dx) * SQW'(dx);
    sqy <= SQW'(dy) * SQW'(dy);
    sum_r <= SUM_BITS'(sqx) + SUM_BITS'(sqy);
  end

  assign tag_out = tag3;
  assign sum = sum_r;

endmodule

/* sv/nuns_sqrt.sv */
module nuns_sqrt #(
  parameter int SUM_BITS = 35
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [SUM_BITS-1:0]           d2,
  output logic                          done,
  output logic [nuns_pkg::DIST_BITS-1:0] root
);

  localparam int EW = (SUM_BITS > 35) ? SUM_BITS : 35;
  localparam int VW = 51;

  logic [EW-1:0] d2e;
  logic [VW-1:0] v;
  logic [VW-1:0] res;
  logic [VW-1:0] bitm;
  logic [VW-1:0] trial;
  logic [4:0] cnt;
  logic run;

  assign d2e = EW'(d2);
  assign trial = res + bitm;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        if (d2e >= (EW'(1) << 34)) begin
          res <= VW'(nuns_pkg::DIST_ONES);
          done <= 1'b1;
        end else begin
          v <= VW'(d2e[33:0]) << 16;
          res <= '0;
          bitm <= VW'(1) << 48;
          cnt <= '0;
          run <= 1'b1;
          done <= 1'b0;
        end
      end else if (run) begin
        if (v >= trial) begin
          v <= v - trial;
          res <= (res >> 1) + bitm;
        end else begin
          res <= res >> 1;
        end
        bitm <= bitm >> 2;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd24) begin
          run <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign root = res[nuns_pkg::DIST_BITS-1:0];

endmodule

/* sv/nearest_unvisited_node_search.sv */
// Nearest unvisited node search over a ring of coordinate cells.
// A command is taken when start is high and busy is low. Action 0 loads
// one node's x and y, action 1 finds the nearest unvisited node to
// node_index under visited_mask, and action 2 returns the fixed-point
// distance between node_index and other_node.
// Each command ends with one result transfer: done is high for exactly one
// cycle with closest_node, found and distance valid; the receiver cannot
// stall it. busy stays high from acceptance until that cycle has passed.
// The coordinates circulate through MAX_NODES cells; every load, closest
// or distance command makes one full revolution. A closest query makes a
// second revolution feeding the distance pipeline, and a distance query
// adds the pipeline and a 25-step square root.
// node_count is written through cfg_write and cfg_data; the user must
// write it only while idle, as the block itself does not enforce this.
// Reset returns to idle and sets node_count to 64; stored coordinates are
// undefined until loaded.
module nearest_unvisited_node_search #(
  parameter int MAX_NODES = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          action,
  input  logic [nuns_pkg::NODE_BITS-1:0]      node_index,
  input  logic [nuns_pkg::NODE_BITS-1:0]      other_node,
  input  logic signed [15:0]                  coord_x,
  input  logic signed [15:0]                  coord_y,
  input  logic [63:0]                         visited_mask,
  output logic                                done,
  output logic [nuns_pkg::NODE_BITS-1:0]      closest_node,
  output logic                                found,
  output logic [nuns_pkg::DIST_BITS-1:0]      distance,
  input  logic                                cfg_write,
  input  logic [nuns_pkg::COUNT_BITS-1:0]     cfg_data
);

  localparam int SUM_BITS = 2 * COORD_BITS + 3;
  localparam int CW = nuns_pkg::COUNT_BITS;
  localparam logic [CW-1:0] MAXC = CW'(MAX_NODES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GATHER = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FEED = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_SQRT = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state;
  logic [CW-1:0] node_count;
  logic [CW-1:0] cnt;
  logic [1:0] op;
  logic [nuns_pkg::NODE_BITS-1:0] a;
  logic [nuns_pkg::NODE_BITS-1:0] b;
  logic [63:0] mask;
  logic signed [COORD_BITS-1:0] ld_x;
  logic signed [COORD_BITS-1:0] ld_y;
  logic signed [COORD_BITS-1:0] ox;
  logic signed [COORD_BITS-1:0] oy;
  logic signed [COORD_BITS-1:0] bx;
  logic signed [COORD_BITS-1:0] by;
  logic [SUM_BITS-1:0] best;
  logic [nuns_pkg::NODE_BITS-1:0] closest_r;
  logic found_r;
  logic [nuns_pkg::DIST_BITS-1:0] dist_r;

  logic signed [COORD_BITS-1:0] cx [MAX_NODES];
  logic signed [COORD_BITS-1:0] cy [MAX_NODES];
  logic signed [COORD_BITS-1:0] tail_x;
  logic signed [COORD_BITS-1:0] tail_y;
  logic shift;
  logic [CW-1:0] n_use;
  logic [nuns_pkg::NODE_BITS-1:0] ci;
  logic hit_a;
  logic last;
  logic signed [31:0] wx;
  logic signed [31:0] wy;

  nuns_pkg::tag_t tag_in;
  nuns_pkg::tag_t tag_out;
  logic signed [COORD_BITS-1:0] pbx;
  logic signed [COORD_BITS-1:0] pby;
  logic [SUM_BITS-1:0] sum;
  logic sq_start;
  logic sq_done;
  logic [nuns_pkg::DIST_BITS-1:0] sq_root;

  assign ci = cnt[nuns_pkg::NODE_BITS-1:0];
  assign hit_a = (ci == a);
  assign last = (cnt == MAXC - CW'(1));
  assign n_use = (node_count > MAXC) ? MAXC : node_count;
  assign shift = (state == S_GATHER) || (state == S_SCAN);
  assign wx = 32'(coord_x);
  assign wy = 32'(coord_y);

  always_comb begin
    if (state == S_GATHER && op == nuns_pkg::ACT_LOAD && hit_a) begin
      tail_x = ld_x;
      tail_y = ld_y;
    end else begin
      tail_x = cx[0];
      tail_y = cy[0];
    end
  end

  for (genvar k = 0; k < MAX_NODES; k++) begin : g_ring
    if (k == MAX_NODES - 1) begin : g_tail
      nuns_cell #(.COORD_BITS(COORD_BITS)) u_cell (
        .clk(clk), .shift(shift), .x_in(tail_x), .y_in(tail_y),
        .x_out(cx[k]), .y_out(cy[k])
      );
    end else begin : g_mid
      nuns_cell #(.COORD_BITS(COORD_BITS)) u_cell (
        .clk(clk), .shift(shift), .x_in(cx[k+1]), .y_in(cy[k+1]),
        .x_out(cx[k]), .y_out(cy[k])
      );
    end
  end

  always_comb begin
    tag_in.valid = 1'b0;
    tag_in.idx = ci;
    pbx = cx[0];
    pby = cy[0];
    if (state == S_SCAN) begin
      tag_in.valid = (cnt < n_use) && !hit_a && !mask[ci];
    end else if (state == S_FEED) begin
      tag_in.valid = 1'b1;
      pbx = bx;
      pby = by;
    end
  end

  nuns_dist #(.COORD_BITS(COORD_BITS), .SUM_BITS(SUM_BITS)) u_dist (
    .clk(clk), .rst(rst), .tag_in(tag_in), .ax(ox), .ay(oy),
    .bx(pbx), .by(pby), .tag_out(tag_out), .sum(sum)
  );

  assign sq_start = (state == S_DRAIN) && (op == nuns_pkg::ACT_DISTANCE)
                    && (cnt == CW'(2));

  nuns_sqrt #(.SUM_BITS(SUM_BITS)) u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .d2(sum),
    .done(sq_done), .root(sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      node_count <= CW'(64);
    end else begin
      if (cfg_write) begin
        node_count <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            op <= action;
            a <= node_index;
            b <= other_node;
            mask <= visited_mask;
            ld_x <= wx[COORD_BITS-1:0];
            ld_y <= wy[COORD_BITS-1:0];
            cnt <= '0;
            closest_r <= '0;
            found_r <= 1'b0;
            dist_r <= '0;
            if (action > nuns_pkg::ACT_DISTANCE) begin
              state <= S_DONE;
            end else begin
              state <= S_GATHER;
            end
          end
        end
        S_GATHER: begin
          if (hit_a) begin
            ox <= cx[0];
            oy <= cy[0];
          end
          if (ci == b) begin
            bx <= cx[0];
            by <= cy[0];
          end
          if (last) begin
            cnt <= '0;
            if (op == nuns_pkg::ACT_CLOSEST) begin
              state <= ({1'b0, a} < n_use) ? S_SCAN : S_DONE;
            end else if (op == nuns_pkg::ACT_DISTANCE) begin
              if (a == b || {1'b0, a} >= n_use || {1'b0, b} >= n_use) begin
                dist_r <= nuns_pkg::DIST_ONES;
                state <= S_DONE;
              end else begin
                state <= S_FEED;
              end
            end else begin
              state <= S_DONE;
            end
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_SCAN: begin
          if (last) begin
            cnt <= '0;
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_FEED: begin
          cnt <= '0;
          state <= S_DRAIN;
        end
        S_DRAIN: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(2)) begin
            state <= (op == nuns_pkg::ACT_DISTANCE) ? S_SQRT : S_DONE;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            dist_r <= sq_root;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (op == nuns_pkg::ACT_CLOSEST && tag_out.valid
          && (!found_r || sum < best)) begin
        best <= sum;
        closest_r <= tag_out.idx;
        found_r <= 1'b1;
      end
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  assign closest_node = closest_r;
  assign found = found_r;
  assign distance = dist_r;

endmodule

/* verif/nearest_unvisited_node_search_checker.sv */
`timescale 1ns / 1ps

module nearest_unvisited_node_search_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic [1:0]                      action,
  input  logic [nuns_pkg::NODE_BITS-1:0]  node_index,
  input  logic [nuns_pkg::NODE_BITS-1:0]  other_node,
  input  logic signed [15:0]              coord_x,
  input  logic signed [15:0]              coord_y,
  input  logic [63:0]                     visited_mask,
  input  logic                            done,
  input  logic [nuns_pkg::NODE_BITS-1:0]  closest_node,
  input  logic                            found,
  input  logic [nuns_pkg::DIST_BITS-1:0]  distance,
  input  logic                            cfg_write,
  input  logic [nuns_pkg::COUNT_BITS-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);

  typedef struct packed {
    logic [nuns_pkg::NODE_BITS-1:0] node;
    logic                           hit;
    logic [nuns_pkg::DIST_BITS-1:0] dist_fx;
  } answer_t;

  answer_t answers[$];
  logic signed [15:0] xs[64];
  logic signed [15:0] ys[64];
  logic [nuns_pkg::COUNT_BITS-1:0] count_reg;

  assign pending = answers.size();

  function automatic longint unsigned square_dist(int a, int b);
    longint dx, dy;
    dx = longint'(xs[a]) - longint'(xs[b]);
    dy = longint'(ys[a]) - longint'(ys[b]);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return longint'(dx * dx + dy * dy);
  endfunction

  function automatic logic [nuns_pkg::DIST_BITS-1:0] root_fixed(longint unsigned d2);
    longint unsigned v, res, bitv;
    if (d2 >= (64'd1 << 34)) return nuns_pkg::DIST_ONES;
    v = d2 << 16;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    if (res > 64'h1FFFFFF) return nuns_pkg::DIST_ONES;
    return res[nuns_pkg::DIST_BITS-1:0];
  endfunction

  function automatic answer_t predict_answer();
    answer_t r;
    int n, a, b;
    longint unsigned best, d2;
    r = '0;
    n = (count_reg > 64) ? 64 : int'(count_reg);
    a = int'(node_index);
    b = int'(other_node);
    best = 0;
    if (action == nuns_pkg::ACT_CLOSEST) begin
      if (a < n) begin
        for (int i = 0; i < n; i++) begin
          if (i != a && !visited_mask[i]) begin
            d2 = square_dist(a, i);
            if (!r.hit || d2 < best) begin
              best = d2;
              r.node = i[nuns_pkg::NODE_BITS-1:0];
              r.hit = 1'b1;
            end
          end
        end
      end
    end else if (action == nuns_pkg::ACT_DISTANCE) begin
      if (a == b || a >= n || b >= n) r.dist_fx = nuns_pkg::DIST_ONES;
      else r.dist_fx = root_fixed(square_dist(a, b));
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    answer_t e;
    if (rst) begin
      count_reg <= 7'd64;
      answers.delete();
    end else begin
      if (done) begin
        if (answers.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          e = answers.pop_front();
          if (closest_node !== e.node)
            report_mismatch($sformatf("closest_node %0d, expected %0d", closest_node, e.node));
          if (found !== e.hit)
            report_mismatch($sformatf("found %0b, expected %0b", found, e.hit));
          if (distance !== e.dist_fx)
            report_mismatch($sformatf("distance %0h, expected %0h", distance, e.dist_fx));
        end
      end
      if (start && !busy) begin
        answers.push_back(predict_answer());
        if (action == nuns_pkg::ACT_LOAD) begin
          xs[node_index] <= coord_x;
          ys[node_index] <= coord_y;
        end
      end
      if (cfg_write) count_reg <= cfg_data;
    end
  end

endmodule

/* verif/nearest_unvisited_node_search_tb.sv */
`timescale 1ns / 1ps

module nearest_unvisited_node_search_tb;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk, rst, start, busy, done, found, cfg_write;
  logic [1:0] action;
  logic [nuns_pkg::NODE_BITS-1:0] node_index, other_node, closest_node;
  logic signed [15:0] coord_x, coord_y;
  logic [63:0] visited_mask;
  logic [nuns_pkg::DIST_BITS-1:0] distance;
  logic [nuns_pkg::COUNT_BITS-1:0] cfg_data;
  int fail_count, pending, cycles;
  logic [63:0] loaded;
  int burst_left;

  nearest_unvisited_node_search dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .node_index(node_index), .other_node(other_node), .coord_x(coord_x),
    .coord_y(coord_y), .visited_mask(visited_mask), .done(done),
    .closest_node(closest_node), .found(found), .distance(distance),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  nearest_unvisited_node_search_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .node_index(node_index), .other_node(other_node), .coord_x(coord_x),
    .coord_y(coord_y), .visited_mask(visited_mask), .done(done),
    .closest_node(closest_node), .found(found), .distance(distance),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // One transfer: hold the command until an edge where busy is low.
  task automatic issue(logic [1:0] act, int a, int b, int x, int y, logic [63:0] mask);
    logic was_busy;
    @(negedge clk);
    action = act;
    node_index = a[nuns_pkg::NODE_BITS-1:0];
    other_node = b[nuns_pkg::NODE_BITS-1:0];
    coord_x = x[15:0];
    coord_y = y[15:0];
    visited_mask = mask;
    start = 1'b1;
    forever begin
      was_busy = busy;
      @(posedge clk);
      if (!was_busy) break;
      @(negedge clk);
    end
    if (act == nuns_pkg::ACT_LOAD) loaded[a] = 1'b1;
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        @(negedge clk);
        start = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic write_count(logic [nuns_pkg::COUNT_BITS-1:0] v);
    @(negedge clk);
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    cfg_write = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic random_item();
    int a, b, sel;
    logic [63:0] mask;
    a = $urandom_range(0, 63);
    b = ($urandom_range(0, 7) == 0) ? a : $urandom_range(0, 63);
    sel = $urandom_range(0, 9);
    mask = {$urandom, $urandom};
    if ($urandom_range(0, 7) == 0) mask = '0;
    mask = mask | ~loaded;
    if (sel < 3 || !loaded[a] || (sel >= 6 && !loaded[b])) begin
      if (sel >= 6 && loaded[a]) a = b;
      issue(nuns_pkg::ACT_LOAD, a, b, int'($urandom), int'($urandom), mask);
    end else if (sel < 6) begin
      issue(nuns_pkg::ACT_CLOSEST, a, b, int'($urandom), int'($urandom), mask);
    end else begin
      issue(nuns_pkg::ACT_DISTANCE, a, b, int'($urandom), int'($urandom), mask);
    end
    pace();
  endtask

  initial begin
    logic [nuns_pkg::COUNT_BITS-1:0] counts[8];
    rst = 1'b1;
    start = 1'b0;
    action = nuns_pkg::ACT_LOAD;
    node_index = '0;
    other_node = '0;
    coord_x = '0;
    coord_y = '0;
    visited_mask = '0;
    cfg_write = 1'b0;
    cfg_data = '0;
    loaded = '0;
    burst_left = 0;
    counts = '{7'd64, 7'd1, 7'd2, 7'd0, 7'd127, 7'd7, 7'd33, 7'd64};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    issue(nuns_pkg::ACT_LOAD, 0, 0, -32768, -32768, '0);
    issue(nuns_pkg::ACT_LOAD, 1, 0, 32767, 32767, '0);
    issue(nuns_pkg::ACT_LOAD, 2, 0, 0, 0, '0);
    issue(nuns_pkg::ACT_LOAD, 3, 0, -32768, 32767, '0);
    issue(nuns_pkg::ACT_LOAD, 4, 0, 32767, -32768, '0);
    issue(nuns_pkg::ACT_LOAD, 5, 0, 0, 0, '0);
    issue(nuns_pkg::ACT_LOAD, 63, 0, 12, -7, '0);
    issue(nuns_pkg::ACT_CLOSEST, 2, 0, 0, 0, ~loaded);
    issue(nuns_pkg::ACT_CLOSEST, 0, 0, 0, 0, ~loaded);
    issue(nuns_pkg::ACT_CLOSEST, 1, 0, 0, 0, '1);
    issue(nuns_pkg::ACT_CLOSEST, 63, 0, 0, 0, ~loaded | 64'h3C);
    issue(nuns_pkg::ACT_DISTANCE, 0, 1, 0, 0, '0);
    issue(nuns_pkg::ACT_DISTANCE, 3, 4, 0, 0, '1);
    issue(nuns_pkg::ACT_DISTANCE, 2, 5, 0, 0, '0);
    issue(nuns_pkg::ACT_DISTANCE, 2, 2, 0, 0, '0);
    issue(nuns_pkg::ACT_DISTANCE, 63, 0, 0, 0, '0);
    write_count(7'd2);
    issue(nuns_pkg::ACT_CLOSEST, 63, 0, 0, 0, '0);
    issue(nuns_pkg::ACT_CLOSEST, 0, 0, 0, 0, '0);
    issue(nuns_pkg::ACT_DISTANCE, 0, 5, 0, 0, '0);
    issue(nuns_pkg::ACT_DISTANCE, 1, 0, 0, 0, '0);

    for (int p = 0; p < 8; p++) begin
      write_count(counts[p]);
      repeat (90) random_item();
      write_count(7'($urandom_range(1, 64)));
      repeat (40) random_item();
    end

    @(negedge clk);
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/nuns_pkg.sv
sv/nuns_cell.sv
sv/nuns_dist.sv
sv/nuns_sqrt.sv
sv/nearest_unvisited_node_search.sv
verif/nearest_unvisited_node_search_checker.sv
verif/nearest_unvisited_node_search_tb.sv
